// File: design/brsc_pkg.sv
// Shared constants for the square-crop box regression block.
// Field widths, configuration register indexes and the coefficient helper.
// No dependencies.
package brsc_pkg;

    localparam int COEF_FRAC_BITS_DEF  = 15;
    localparam int COORD_FRAC_BITS_DEF = 4;

    localparam int COORD_W   = 18;  // box edge, signed
    localparam int CROP_LT_W = 15;  // crop left/top, unsigned
    localparam int CROP_RB_W = 16;  // crop right/bottom, signed
    localparam int IMG_W     = 14;  // image size registers
    localparam int REG_IDX_W = 1;

    localparam int S_DATA_W = 4 * COORD_W;
    localparam int M_DATA_W = 64;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Matrix entry given in units of 1/10000, rounded to frac fraction bits.
    // Used at elaboration only.
    function automatic longint coef_q(input int e4, input int frac);
        longint k;
        k = ((longint'(e4) << frac) + 64'sd5000) / 64'sd10000;
        return k;
    endfunction

endpackage

// File: design/box_regression_square_crop.sv
// Square crop from a detected box: regression, 1.2x side, centering, clamps.
// Depends on brsc_pkg.
//
//  channel | dir | beat content
//  --------+-----+--------------------------------------------------------
//  s_*     | in  | box_left, box_top, box_right, box_bottom (Q.4 pixels)
//  m_*     | out | crop_left, crop_top, crop_right, crop_bottom; tuser=degenerate
//  cfg_*   | in  | image_width (index 0), image_height (index 1)
//
// Nine register stages, the last one the output register; one beat per cycle
// sustained while m_tready is high. Each stage has its own valid bit and moves
// when it is empty or the stage after it moves, so bubbles are squeezed out
// and a stall on m_tready loses nothing. Reset clears the valid bits and sets
// both image size registers to 640.
module box_regression_square_crop #(
    parameter int COEF_FRAC_BITS  = brsc_pkg::COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = brsc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // box_left, box_top, box_right, box_bottom (18 bits each)
    input  logic [brsc_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // crop_left[14:0], crop_top[29:15], crop_right[45:30], crop_bottom[61:46], zero pad
    output logic [brsc_pkg::M_DATA_W-1:0]  m_tdata,
    // degenerate
    output logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [brsc_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [brsc_pkg::IMG_W-1:0]     cfg_wdata
);
    import brsc_pkg::*;

    localparam int NSTG = 9;
    localparam int C    = COEF_FRAC_BITS;
    localparam int F    = COEF_FRAC_BITS + COORD_FRAC_BITS;
    localparam int DW   = COORD_W + 1;      // differences and sums of edges
    localparam int KW   = C + 2;            // combined coefficients
    localparam int PW   = C + 21;           // products and regressed sums
    localparam int MW   = C + 23;           // 3*extent and rounding sum
    localparam int QW   = MW - F;           // extent over 2^F
    localparam int K_SH = QW + 3;           // reciprocal shift for /5
    localparam int RCW  = QW + 1;
    localparam int XW   = 2 * QW + 1;       // reciprocal product
    localparam int SW   = QW - 1;           // signed side
    localparam int ZW   = C + 23;           // edge before final rounding
    localparam int LW   = ZW - F;           // rounded left/top
    localparam int RSW  = LW + 1;           // left + side

    localparam logic signed [KW-1:0] COEF_A = KW'(coef_q(1801, C) + coef_q(1988, C)
        + coef_q(1177, C) + coef_q(1899, C));
    localparam logic signed [KW-1:0] COEF_B = KW'(coef_q(2433, C) + coef_q(2434, C)
        + coef_q(1699, C) + coef_q(3874, C));
    localparam logic signed [KW-1:0] COEF_P = KW'(coef_q(1988, C) - coef_q(1801, C));
    localparam logic signed [KW-1:0] COEF_Q = KW'(coef_q(2434, C) - coef_q(2433, C));
    localparam logic signed [KW-1:0] COEF_R = KW'(coef_q(1899, C) - coef_q(1177, C));
    localparam logic signed [KW-1:0] COEF_S = KW'(coef_q(3874, C) - coef_q(1699, C));

    localparam logic [MW-1:0]  HALF5   = MW'(64'd5 << (F - 1));
    localparam logic [RCW-1:0] RECIP   = RCW'(((64'd1 << K_SH) + 64'd4) / 64'd5);
    localparam logic signed [ZW:0] RND_POS = (ZW+1)'(64'd1 << F);
    localparam logic signed [ZW:0] RND_NEG = (ZW+1)'((64'd1 << F) - 64'd1);
    localparam logic signed [LW-1:0]  LEFT_MAX  = LW'(32767);
    localparam logic signed [RSW-1:0] RIGHT_MIN = RSW'(-32768);

    // configuration
    logic [IMG_W-1:0] width_reg, width_next;
    logic [IMG_W-1:0] height_reg, height_next;

    // stage handshake
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] adv;

    // input unpack
    logic signed [COORD_W-1:0] box_left, box_top, box_right, box_bottom;

    // stage 1: extents and centre sums
    logic signed [DW-1:0] s1_w_reg, s1_h_reg, s1_sx_reg, s1_sy_reg;
    logic signed [DW-1:0] s1_w_next, s1_h_next, s1_sx_next, s1_sy_next;
    logic                 s1_dg_reg, s1_dg_next;
    // stage 2: constant products
    logic signed [PW-1:0] s2_aw_reg, s2_bh_reg, s2_pw_reg, s2_qh_reg, s2_rw_reg, s2_sh_reg;
    logic signed [PW-1:0] s2_aw_next, s2_bh_next, s2_pw_next, s2_qh_next;
    logic signed [PW-1:0] s2_rw_next, s2_sh_next;
    logic signed [DW-1:0] s2_sx_reg, s2_sy_reg;
    logic                 s2_dg_reg;
    // stage 3: summed extent and doubled regressed centres
    logic signed [PW-1:0] s3_e_reg, s3_x_reg, s3_y_reg;
    logic signed [PW-1:0] s3_e_next, s3_x_next, s3_y_next;
    logic                 s3_dg_reg;
    // stage 4: three times the extent
    logic signed [MW-1:0] s4_t3_reg, s4_t3_next;
    logic signed [PW-1:0] s4_x_reg, s4_y_reg;
    logic                 s4_dg_reg;
    // stage 5: rounded magnitude over 2^F
    logic [MW-1:0]        s5_m;
    logic [QW-1:0]        s5_q_reg, s5_q_next;
    logic                 s5_neg_reg, s5_neg_next;
    logic signed [PW-1:0] s5_x_reg, s5_y_reg;
    logic                 s5_dg_reg;
    // stage 6: divide by five
    logic [XW-1:0]        s6_prod;
    logic [QW-3:0]        s6_mag_reg, s6_mag_next;
    logic                 s6_neg_reg;
    logic signed [PW-1:0] s6_x_reg, s6_y_reg;
    logic                 s6_dg_reg;
    // stage 7: centre minus side
    logic signed [ZW-1:0] s7_shift;
    logic signed [ZW-1:0] s7_zl_reg, s7_zt_reg, s7_zl_next, s7_zt_next;
    logic signed [SW-1:0] s7_side_reg, s7_side_next;
    logic                 s7_dg_reg;
    // stage 8: final rounding
    logic signed [ZW:0]   s8_suml, s8_sumt;
    logic signed [LW-1:0] s8_left_reg, s8_top_reg, s8_left_next, s8_top_next;
    logic signed [SW-1:0] s8_side_reg;
    logic                 s8_dg_reg;
    // stage 9: clamps, output register
    logic signed [RSW-1:0] s9_left, s9_top, s9_right, s9_bottom, s9_capw, s9_caph;
    logic [CROP_LT_W-1:0] crop_left_reg, crop_top_reg, crop_left_next, crop_top_next;
    logic [CROP_RB_W-1:0] crop_right_reg, crop_bottom_reg;
    logic [CROP_RB_W-1:0] crop_right_next, crop_bottom_next;
    logic                 degen_reg;

    assign box_left   = s_tdata[COORD_W-1:0];
    assign box_top    = s_tdata[2*COORD_W-1:COORD_W];
    assign box_right  = s_tdata[3*COORD_W-1:2*COORD_W];
    assign box_bottom = s_tdata[4*COORD_W-1:3*COORD_W];

    // ---------------------------------------------------------------- control
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            width_reg  <= IMG_W'(640);
            height_reg <= IMG_W'(640);
        end
        else
        begin
            vld_reg    <= vld_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        // stage 1
        s1_w_next  = DW'(box_right) - DW'(box_left);
        s1_h_next  = DW'(box_bottom) - DW'(box_top);
        s1_sx_next = DW'(box_left) + DW'(box_top) - DW'(box_top) + DW'(box_right);
        s1_sy_next = DW'(box_top) + DW'(box_bottom);
        s1_dg_next = ((DW+1)'(s1_w_next) + (DW+1)'(s1_h_next)) <= 0;

        // stage 2
        s2_aw_next = PW'(s1_w_reg) * PW'(COEF_A);
        s2_bh_next = PW'(s1_h_reg) * PW'(COEF_B);
        s2_pw_next = PW'(s1_w_reg) * PW'(COEF_P);
        s2_qh_next = PW'(s1_h_reg) * PW'(COEF_Q);
        s2_rw_next = PW'(s1_w_reg) * PW'(COEF_R);
        s2_sh_next = PW'(s1_h_reg) * PW'(COEF_S);

        // stage 3
        s3_e_next = s2_aw_reg + s2_bh_reg;
        s3_x_next = (PW'(s2_sx_reg) <<< C) + s2_pw_reg + s2_qh_reg;
        s3_y_next = (PW'(s2_sy_reg) <<< C) + s2_rw_reg + s2_sh_reg;

        // stage 4
        s4_t3_next = MW'(s3_e_reg) + (MW'(s3_e_reg) <<< 1);

        // stage 5: |3E| + 2.5*2^F, one adder either way
        s5_neg_next = s4_t3_reg[MW-1];
        s5_m        = s5_neg_next ? (HALF5 - $unsigned(s4_t3_reg))
                                  : (HALF5 + $unsigned(s4_t3_reg));
        s5_q_next   = s5_m[MW-1:F];

        // stage 6: floor(q/5) by reciprocal, exact over the whole q range
        s6_prod     = XW'(s5_q_reg) * XW'(RECIP);
        s6_mag_next = s6_prod[XW-1:K_SH];

        // stage 7
        s7_side_next = s6_neg_reg ? -SW'(s6_mag_reg) : SW'(s6_mag_reg);
        s7_shift     = $signed(ZW'(s6_mag_reg) << F);
        s7_zl_next   = s6_neg_reg ? ZW'(s6_x_reg) + s7_shift : ZW'(s6_x_reg) - s7_shift;
        s7_zt_next   = s6_neg_reg ? ZW'(s6_y_reg) + s7_shift : ZW'(s6_y_reg) - s7_shift;

        // stage 8: halves away from zero, one bias add then arithmetic shift
        s8_suml      = (ZW+1)'(s7_zl_reg) + (s7_zl_reg[ZW-1] ? RND_NEG : RND_POS);
        s8_sumt      = (ZW+1)'(s7_zt_reg) + (s7_zt_reg[ZW-1] ? RND_NEG : RND_POS);
        s8_left_next = s8_suml[ZW:F+1];
        s8_top_next  = s8_sumt[ZW:F+1];

        // stage 9
        s9_left   = RSW'(s8_left_reg);
        s9_top    = RSW'(s8_top_reg);
        s9_right  = s9_left + RSW'(s8_side_reg);
        s9_bottom = s9_top + RSW'(s8_side_reg);
        s9_capw   = RSW'($signed({1'b0, width_reg}));
        s9_caph   = RSW'($signed({1'b0, height_reg}));

        if (s8_left_reg < 0)
            crop_left_next = '0;
        else if (s8_left_reg > LEFT_MAX)
            crop_left_next = CROP_LT_W'(LEFT_MAX);
        else
            crop_left_next = CROP_LT_W'(s8_left_reg);

        if (s8_top_reg < 0)
            crop_top_next = '0;
        else if (s8_top_reg > LEFT_MAX)
            crop_top_next = CROP_LT_W'(LEFT_MAX);
        else
            crop_top_next = CROP_LT_W'(s8_top_reg);

        // cap never exceeds 16383, so only the low side needs saturating
        if (s9_right > s9_capw)
            crop_right_next = CROP_RB_W'(s9_capw);
        else if (s9_right < RIGHT_MIN)
            crop_right_next = CROP_RB_W'(RIGHT_MIN);
        else
            crop_right_next = CROP_RB_W'(s9_right);

        if (s9_bottom > s9_caph)
            crop_bottom_next = CROP_RB_W'(s9_caph);
        else if (s9_bottom < RIGHT_MIN)
            crop_bottom_next = CROP_RB_W'(RIGHT_MIN);
        else
            crop_bottom_next = CROP_RB_W'(s9_bottom);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_w_reg  <= s1_w_next;
            s1_h_reg  <= s1_h_next;
            s1_sx_reg <= s1_sx_next;
            s1_sy_reg <= s1_sy_next;
            s1_dg_reg <= s1_dg_next;
        end
        if (adv[1])
        begin
            s2_aw_reg <= s2_aw_next;
            s2_bh_reg <= s2_bh_next;
            s2_pw_reg <= s2_pw_next;
            s2_qh_reg <= s2_qh_next;
            s2_rw_reg <= s2_rw_next;
            s2_sh_reg <= s2_sh_next;
            s2_sx_reg <= s1_sx_reg;
            s2_sy_reg <= s1_sy_reg;
            s2_dg_reg <= s1_dg_reg;
        end
        if (adv[2])
        begin
            s3_e_reg  <= s3_e_next;
            s3_x_reg  <= s3_x_next;
            s3_y_reg  <= s3_y_next;
            s3_dg_reg <= s2_dg_reg;
        end
        if (adv[3])
        begin
            s4_t3_reg <= s4_t3_next;
            s4_x_reg  <= s3_x_reg;
            s4_y_reg  <= s3_y_reg;
            s4_dg_reg <= s3_dg_reg;
        end
        if (adv[4])
        begin
            s5_q_reg   <= s5_q_next;
            s5_neg_reg <= s5_neg_next;
            s5_x_reg   <= s4_x_reg;
            s5_y_reg   <= s4_y_reg;
            s5_dg_reg  <= s4_dg_reg;
        end
        if (adv[5])
        begin
            s6_mag_reg <= s6_mag_next;
            s6_neg_reg <= s5_neg_reg;
            s6_x_reg   <= s5_x_reg;
            s6_y_reg   <= s5_y_reg;
            s6_dg_reg  <= s5_dg_reg;
        end
        if (adv[6])
        begin
            s7_zl_reg   <= s7_zl_next;
            s7_zt_reg   <= s7_zt_next;
            s7_side_reg <= s7_side_next;
            s7_dg_reg   <= s6_dg_reg;
        end
        if (adv[7])
        begin
            s8_left_reg <= s8_left_next;
            s8_top_reg  <= s8_top_next;
            s8_side_reg <= s7_side_reg;
            s8_dg_reg   <= s7_dg_reg;
        end
        if (adv[8])
        begin
            crop_left_reg   <= crop_left_next;
            crop_top_reg    <= crop_top_next;
            crop_right_reg  <= crop_right_next;
            crop_bottom_reg <= crop_bottom_next;
            degen_reg       <= s8_dg_reg;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {(M_DATA_W - 2*CROP_LT_W - 2*CROP_RB_W)'(0), crop_bottom_reg,
                       crop_right_reg, crop_top_reg, crop_left_reg};
    assign m_tuser  = degen_reg;

endmodule
